>>> hw/rtl/bpl_pkg.sv
package bpl_pkg;

    // List dimensions
    localparam int CAPACITY = 8;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int LEN_W    = 4;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request operation codes
    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_INSERT = 3'd1,
        OP_UPDATE = 3'd2,
        OP_DELETE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word_in;
    } req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] word_out;
        logic [LEN_W-1:0]         length;
    } res_t;

endpackage

>>> hw/rtl/bpl_store.sv
module bpl_store (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          commit,
    input  bpl_pkg::req_t req,
    output bpl_pkg::res_t res
);
    import bpl_pkg::*;

    logic signed [WORD_W-1:0] ent_reg  [CAPACITY];
    logic signed [WORD_W-1:0] ent_next [CAPACITY];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     in_range;
    logic                     full;
    logic                     ok;
    logic signed [WORD_W-1:0] rd_word;
    logic [CNT_W+LEN_W-1:0]   len_wide;

    assign pos_ext  = CMP_W'(req.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign in_range = pos_ext < cnt_ext;
    assign full     = count_reg == CNT_W'(CAPACITY);

    // Decode the request and work out the shifted store in parallel
    always_comb begin
        ok         = 1'b0;
        rd_word    = '0;
        count_next = count_reg;
        for (int i = 0; i < CAPACITY; i++) begin
            ent_next[i] = ent_reg[i];
        end
        unique case (req.op)
            OP_READ: begin
                if (in_range) begin
                    ok      = 1'b1;
                    rd_word = ent_reg[pos_ext[IDX_W-1:0]];
                end
            end
            OP_INSERT: begin
                if (!full && pos_ext <= cnt_ext) begin
                    ok = 1'b1;
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (CMP_W'(i) > pos_ext) begin
                            ent_next[i] = ent_reg[i-1];
                        end
                    end
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CMP_W'(i) == pos_ext) begin
                            ent_next[i] = req.word_in;
                        end
                    end
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_UPDATE: begin
                if (in_range) begin
                    ok = 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CMP_W'(i) == pos_ext) begin
                            ent_next[i] = req.word_in;
                        end
                    end
                end
            end
            OP_DELETE: begin
                if (in_range) begin
                    ok = 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (CMP_W'(i) >= pos_ext) begin
                            ent_next[i] = ent_reg[i+1];
                        end
                    end
                    count_next = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_CLEAR: begin
                ok         = 1'b1;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Report length as the count masked to the field width
    assign len_wide     = {{LEN_W{1'b0}}, count_next};
    assign res.ok       = ok;
    assign res.word_out = rd_word;
    assign res.length   = len_wide[LEN_W-1:0];

    // Hold the words until a request commits
    always_ff @(posedge aclk) begin
        if (commit) begin
            for (int i = 0; i < CAPACITY; i++) begin
                ent_reg[i] <= ent_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (commit) begin
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && req.op == OP_INSERT && ok)
        |=> (count_reg == CNT_W'($past(count_reg) + 1'b1)))
        else $error("successful insert did not grow the list by one");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && req.op == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries in the list");
`endif

endmodule

>>> hw/rtl/bounded_positional_list.sv
// Channel   Direction  Ports                                     Handshake
// request   in         s_operation, s_position, s_word_in        s_valid / s_ready
// result    out        m_ok, m_word_out, m_length                m_valid / m_ready
//
// One request per cycle sustained while m_ready holds; a result passes through the request
// register and then the result register. The rate is set by the register store, which shifts every entry at once.
// Reset (aresetn low, synchronous) empties the list and both stage registers.
// A stalled result holds; the request register still takes one more transfer.
module bounded_positional_list (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_operation,
    input  logic [bpl_pkg::POS_W-1:0]         s_position,
    input  logic signed [bpl_pkg::WORD_W-1:0] s_word_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic signed [bpl_pkg::WORD_W-1:0] m_word_out,
    output logic [bpl_pkg::LEN_W-1:0]         m_length
);
    import bpl_pkg::*;

    logic in_valid_reg;
    req_t req_reg;
    logic out_valid_reg;
    res_t res_reg;
    res_t res_comb;
    logic advance;

    // Move the held request into the result register when that is free or being read out
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bpl_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .req     (req_reg),
        .res     (res_comb)
    );

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.op       <= op_t'(s_operation);
            req_reg.position <= s_position;
            req_reg.word_in  <= s_word_in;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_ok       = res_reg.ok;
    assign m_word_out = res_reg.word_out;
    assign m_length   = res_reg.length;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || !in_valid_reg) |-> s_ready)
        else $error("request side stalled with room in the pipeline");

    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("committed request produced no result");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_word_out == '0))
        else $error("rejected request returned a word");
`endif

endmodule
